@@ rtl/dtpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpm_pkg
// Shared sizes, codes and types for the decimal trie prefix match core.
// ----------------------------------------------------------------------------
package dtpm_pkg;

  localparam int NODES     = 512;
  localparam int RADIX     = 10;
  localparam int NODE_W    = $clog2(NODES);
  localparam int FREE_W    = $clog2(NODES + 1);
  localparam int ROW_W     = RADIX * NODE_W;
  localparam int DIGIT_W   = 4;
  localparam int ACTION_W  = 2;
  localparam int COUNT_W   = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // Input action codes.
  localparam logic [ACTION_W-1:0] ACT_INS_DIGIT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_END   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MAT_DIGIT = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_MAT_END   = 2'd3;

  // Result kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_MATCH  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    PHASE_WALK = 2'd0,
    PHASE_FULL = 2'd1,
    PHASE_STOP = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  // Walk state and item handed to the step logic.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DIGIT_W-1:0]  digit;
    phase_t              phase;
    logic [COUNT_W-1:0]  count;
    logic [FREE_W-1:0]   free;
  } step_ctx_t;

  // Updates produced by the step logic for one item.
  typedef struct packed {
    logic                cursor_load;
    logic [NODE_W-1:0]   cursor;
    logic [COUNT_W-1:0]  count;
    phase_t              phase;
    logic                free_inc;
    logic                row_we;
    logic [ROW_W-1:0]    row;
    logic                emit;
    logic                done_kind;
    logic                status;
    logic [COUNT_W-1:0]  match_length;
  } step_res_t;

endpackage

@@ rtl/decimal_trie_prefix_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_trie_prefix_match_core
// Decimal digit trie held as one row of child pointers per node in a RAM.
// ----------------------------------------------------------------------------
// Every item is accepted in the idle state while the cursor node's row is read
// from the node RAM; the execute state then updates and writes back the row.
// No new item is taken until that read-modify-write has committed.
// An end action loads the output register when it commits, once that is free.
// After reset a clearing pass writes NODES (512) null rows, one per cycle,
// with in_ready low; the walk state resets to the root at once.
module decimal_trie_prefix_match_core
  import dtpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [DIGIT_W-1:0]  in_digit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_done_kind,
  output logic                out_status,
  output logic [COUNT_W-1:0]  out_match_length
);

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   cursor_r, cursor_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  phase_t              phase_r, phase_nxt;
  logic [FREE_W-1:0]   free_r, free_nxt;
  logic [NODE_W-1:0]   clr_r, clr_nxt;
  logic [ACTION_W-1:0] act_r;
  logic [DIGIT_W-1:0]  dig_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r;
  logic                out_status_r;
  logic [COUNT_W-1:0]  out_len_r;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  step_ctx_t         ctx;
  step_res_t         res;
  logic              out_free;
  logic              commit;
  logic              in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  // An end action waits in the execute state until the output register frees.
  assign commit   = (state_r == ST_EXEC) && (!res.emit || out_free);

  assign ctx.action = act_r;
  assign ctx.digit  = dig_r;
  assign ctx.phase  = phase_r;
  assign ctx.count  = count_r;
  assign ctx.free   = free_r;

  dtpm_step u_step (
    .ctx (ctx),
    .row (ram_rdata),
    .res (res)
  );

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = commit && res.row_we;
      ram_waddr = cursor_r;
      ram_wdata = res.row;
    end
  end

  dtpm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cursor_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    free_nxt      = free_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NODE_W'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
          count_nxt = res.count;
          phase_nxt = res.phase;
          if (res.cursor_load) begin
            cursor_nxt = res.cursor;
          end
          if (res.free_inc) begin
            free_nxt = free_r + 1'b1;
          end
          if (res.emit) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= '0;
      count_r     <= '0;
      phase_r     <= PHASE_WALK;
      free_r      <= FREE_W'(1);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      free_r      <= free_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_action;
      dig_r <= in_digit;
    end
    if (commit && res.emit) begin
      out_kind_r   <= res.done_kind;
      out_status_r <= res.status;
      out_len_r    <= res.match_length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_done_kind    = out_kind_r;
  assign out_status       = out_status_r;
  assign out_match_length = out_len_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(NODES))
    else $error("node pool counter ran past the pool size");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_r} < {1'b0, free_r})
    else $error("cursor points at a node that was never allocated");

  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    commit && res.emit |=> cursor_r == '0 && count_r == '0 && phase_r == PHASE_WALK)
    else $error("end action did not return the walk to the root");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(commit && res.emit))
    else $error("result committed over one still waiting");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready && !out_valid_r)
    else $error("handshake active during the clearing pass");

endmodule

@@ rtl/dtpm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dtpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dtpm_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpm_step
// Per-item trie logic: picks the child for a digit out of the node row,
// allocates a node on a missing insert child and judges end actions.
// ----------------------------------------------------------------------------
module dtpm_step
  import dtpm_pkg::*;
(
  input  step_ctx_t        ctx,
  input  logic [ROW_W-1:0] row,
  output step_res_t        res
);

  logic              digit_ok;
  logic [NODE_W-1:0] child;
  logic [ROW_W-1:0]  row_new;
  logic              pool_full;
  logic [COUNT_W-1:0] count_inc;
  logic              has_children;

  assign digit_ok     = ctx.digit < DIGIT_W'(RADIX);
  assign pool_full    = ctx.free >= FREE_W'(NODES);
  assign count_inc    = (ctx.count != COUNT_MAX) ? ctx.count + 1'b1 : ctx.count;
  // A node has children exactly when some slot of its row is non-null.
  assign has_children = |row;

  always_comb begin
    child   = '0;
    row_new = row;
    for (int i = 0; i < RADIX; i++) begin
      if (ctx.digit == DIGIT_W'(i)) begin
        child = row[i*NODE_W +: NODE_W];
        row_new[i*NODE_W +: NODE_W] = ctx.free[NODE_W-1:0];
      end
    end
  end

  always_comb begin
    res              = '0;
    res.cursor       = '0;
    res.count        = ctx.count;
    res.phase        = ctx.phase;
    res.row          = row_new;
    res.done_kind    = KIND_INSERT;
    res.status       = STATUS_OK;
    res.match_length = '0;
    case (ctx.action)
      ACT_INS_DIGIT: begin
        if (ctx.phase == PHASE_WALK && digit_ok) begin
          if (child != '0) begin
            res.cursor_load = 1'b1;
            res.cursor      = child;
            res.count       = count_inc;
          end else if (pool_full) begin
            res.phase = PHASE_FULL;
          end else begin
            res.cursor_load = 1'b1;
            res.cursor      = ctx.free[NODE_W-1:0];
            res.count       = count_inc;
            res.free_inc    = 1'b1;
            res.row_we      = 1'b1;
          end
        end
      end
      ACT_MAT_DIGIT: begin
        if (ctx.phase == PHASE_WALK) begin
          if (digit_ok && child != '0) begin
            res.cursor_load = 1'b1;
            res.cursor      = child;
            res.count       = count_inc;
          end else begin
            res.phase = PHASE_STOP;
          end
        end
      end
      ACT_INS_END: begin
        res.emit        = 1'b1;
        res.done_kind   = KIND_INSERT;
        res.status      = (ctx.phase == PHASE_FULL) ? STATUS_FAIL : STATUS_OK;
        res.cursor_load = 1'b1;
        res.count       = '0;
        res.phase       = PHASE_WALK;
      end
      ACT_MAT_END: begin
        res.emit         = 1'b1;
        res.done_kind    = KIND_MATCH;
        res.status       = has_children ? STATUS_FAIL : STATUS_OK;
        res.match_length = has_children ? '0 : ctx.count;
        res.cursor_load  = 1'b1;
        res.count        = '0;
        res.phase        = PHASE_WALK;
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

endmodule
